### rtl/core/btlpm_pkg.sv
// shared types and constants for the binary trie longest-prefix-match core
// no dependencies
package btlpm_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 6;
  localparam int unsigned StW   = 3;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_OK     = 3'd2,
    ST_BADLEN = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    logic             lookup;
    logic             badlen;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } walk_state_t;

  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    logic [AddrW:0] m;
    m = {(AddrW+1){1'b1}} << (7'd33 - {1'b0, len});
    return m[AddrW:1];
  endfunction

endpackage

### rtl/core/binary_trie_longest_prefix_match_core.sv
// Longest-prefix-match engine for IPv4 over a binary trie, one address bit per level.
// The walk takes an accepted item in S_IDLE; for each node visited on the way down (up to
// 32 trie levels descended) it does a registered node memory read (S_READ) and an
// evaluate step (S_EVAL), then S_DONE registers the result; a bad length goes from the
// take straight to S_DONE. The walk takes the next beat only once the result has been popped,
// so it cannot start an item before it is through with the last one; a front queue of two
// beats accepts items while the walk runs.
// Depends on btlpm_pkg, btlpm_front, btlpm_back.
module binary_trie_longest_prefix_match_core #(
  parameter int unsigned NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [btlpm_pkg::AddrW-1:0]   address,
  input  logic [btlpm_pkg::LenW-1:0]    prefix_len,
  output logic                          empty,
  input  logic                          pop,
  output logic [btlpm_pkg::StW-1:0]     status,
  output logic [btlpm_pkg::AddrW-1:0]   match_prefix,
  output logic [btlpm_pkg::LenW-1:0]    match_len
);
  import btlpm_pkg::*;

  logic req_valid;
  logic req_take;
  req_t req;

  // front: accept and classify
  btlpm_front u_front (
    .clk, .rst, .push, .full, .action, .address, .prefix_len,
    .req_valid, .req, .req_take
  );

  // back: trie walk
  btlpm_back #(.NODES(NODES)) u_back (
    .clk, .rst, .req_valid, .req, .req_take,
    .empty, .pop, .status, .match_prefix, .match_len
  );

endmodule

### rtl/core/btlpm_front.sv
// front end: accepts beats, checks length, masks prefixes, holds a two-entry queue
// depends on btlpm_pkg
module btlpm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [btlpm_pkg::AddrW-1:0]   address,
  input  logic [btlpm_pkg::LenW-1:0]    prefix_len,
  output logic                          req_valid,
  output btlpm_pkg::req_t               req,
  input  logic                          req_take
);
  import btlpm_pkg::*;

  req_t       q [2];
  logic [1:0] cnt;
  logic       rd;
  logic       wr;
  req_t       in_req;
  logic       rd_ptr;
  logic       wr_ptr;

  // classify the incoming beat
  always_comb begin
    in_req.lookup = action;
    in_req.badlen = !action && (prefix_len > LenW'(32));
    in_req.addr   = action ? address : (address & len_mask(prefix_len));
    in_req.len    = prefix_len;
  end

  assign full      = (cnt == 2'd2);
  assign wr        = push && !full;
  assign req_valid = (cnt != 2'd0);
  assign rd        = req_take && req_valid;
  assign req       = q[rd_ptr];

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= in_req;
  end

endmodule

### rtl/core/btlpm_back.sv
// back end: walks the trie in the node memory, one level per read
// depends on btlpm_pkg
module btlpm_back #(
  parameter int unsigned NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  btlpm_pkg::req_t               req,
  output logic                          req_take,
  output logic                          empty,
  input  logic                          pop,
  output logic [btlpm_pkg::StW-1:0]     status,
  output logic [btlpm_pkg::AddrW-1:0]   match_prefix,
  output logic [btlpm_pkg::LenW-1:0]    match_len
);
  import btlpm_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned NW = 2*IW + 1 + LenW + AddrW;

  // node: left, right, valid, len, prefix
  logic [NW-1:0] mem [NODES];
  logic [NW-1:0] rdata;
  logic [IW-1:0] raddr;
  logic          re;
  logic          we;
  logic [IW-1:0] waddr;
  logic [NW-1:0] wdata;

  walk_state_t state, state_next;
  req_t        cur_req;
  logic [IW-1:0] cur;
  logic [LenW-1:0] level;
  logic [IW:0]   free_cnt;
  logic          found;
  logic [AddrW-1:0] best_pfx;
  logic [LenW-1:0]  best_len;
  logic          root_init;
  logic          fresh;

  logic          out_valid;
  logic [StW-1:0] out_st;
  logic [AddrW-1:0] out_pfx;
  logic [LenW-1:0]  out_len;

  // fields of the node just read (root and fresh nodes read as cleared until written)
  logic [IW-1:0]    n_left, n_right;
  logic             n_valid;
  logic [LenW-1:0]  n_len;
  logic [AddrW-1:0] n_pfx;
  logic [NW-1:0]    node;
  assign node = ((cur == '0 && !root_init) || fresh) ? '0 : rdata;
  assign {n_left, n_right, n_valid, n_len, n_pfx} = node;

  logic          bit_sel;
  logic [IW-1:0] child;
  assign bit_sel = cur_req.addr[5'(31 - level[4:0])];
  assign child   = bit_sel ? n_right : n_left;

  // node memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_take = (state == S_IDLE) && req_valid && !out_valid;

  // walk control
  always_comb begin
    state_next = state;
    re = 1'b0; raddr = cur;
    we = 1'b0; waddr = cur; wdata = node;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          state_next = req.badlen ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        re = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (cur_req.lookup) begin
          if (level == LenW'(32) || child == '0) state_next = S_DONE;
          else state_next = S_READ;
        end else if (level == cur_req.len) begin
          if (!n_valid) begin
            we = 1'b1;
            wdata = {n_left, n_right, 1'b1, cur_req.len, cur_req.addr};
          end
          state_next = S_DONE;
        end else if (child != '0) begin
          state_next = S_READ;
        end else if (free_cnt >= (IW+1)'(NODES)) begin
          // a node linked during this walk is left cleared in memory
          we = fresh;
          state_next = S_DONE;
        end else begin
          // link a fresh child into the current node
          we = 1'b1;
          wdata = bit_sel ? {n_left, free_cnt[IW-1:0], n_valid, n_len, n_pfx}
                          : {free_cnt[IW-1:0], n_right, n_valid, n_len, n_pfx};
          state_next = S_READ;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // walk datapath; a freshly allocated node reads as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      free_cnt  <= (IW+1)'(1);
      root_init <= 1'b0;
      out_valid <= 1'b0;
      fresh     <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (we && waddr == '0) root_init <= 1'b1;
      unique case (state)
        S_IDLE: if (req_take) begin
          cur_req  <= req;
          cur      <= '0;
          level    <= '0;
          found    <= 1'b0;
          best_pfx <= '0;
          best_len <= '0;
          fresh    <= 1'b0;
        end
        S_READ: ;
        S_EVAL: begin
          if (cur_req.lookup) begin
            if (n_valid) begin
              found <= 1'b1; best_pfx <= n_pfx; best_len <= n_len;
            end
            if (!(level == LenW'(32) || child == '0)) begin
              cur <= child; level <= level + 1'b1;
            end
          end else if (level == cur_req.len) begin
            ;
          end else if (child != '0) begin
            cur <= child; level <= level + 1'b1;
          end else if (free_cnt >= (IW+1)'(NODES)) begin
            found <= 1'b1;
          end else begin
            cur      <= free_cnt[IW-1:0];
            level    <= level + 1'b1;
            free_cnt <= free_cnt + 1'b1;
            fresh    <= 1'b1;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_pfx   <= '0;
          out_len   <= '0;
          if (cur_req.badlen) out_st <= ST_BADLEN;
          else if (!cur_req.lookup) out_st <= found ? ST_FULL : ST_OK;
          else if (found) begin
            out_st <= ST_HIT; out_pfx <= best_pfx; out_len <= best_len;
          end else out_st <= ST_MISS;
        end
        default: ;
      endcase
    end
  end

  assign empty        = !out_valid;
  assign status       = out_st;
  assign match_prefix = out_pfx;
  assign match_len    = out_len;

endmodule
